// ===== sv/csti_pkg.sv =====
// Shared constants, port widths, beat codes and the 32-bit saturation helper
// for the cubic spline table interpolator. No dependencies.
package csti_pkg;

   localparam int TABLE_DEPTH_DEF   = 1024;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int POINTS_W = 11;
   localparam logic [POINTS_W-1:0] POINTS_RESET = 11'd1024;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 64;

   // wide enough for any exact sum or rounded product before saturation
   localparam int WIDE_W = 72;

   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_EVAL = 1'b1
   } action_type;

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi_lim;
      logic signed [WIDE_W-1:0] lo_lim;
      hi_lim = WIDE_W'(WORD_MAX);
      lo_lim = WIDE_W'(WORD_MIN);
      if (v > hi_lim) begin
         return WORD_MAX;
      end else if (v < lo_lim) begin
         return WORD_MIN;
      end
      return $signed(v[31:0]);
   endfunction

endpackage

// ===== sv/csti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/csti_div.sv =====
// Pipelined signed divider: num / den rounded to nearest, ties away from zero,
// saturated to 32 bits, one quotient bit per stage. Uses csti_pkg.
module csti_div import csti_pkg::*; #(
   parameter int NUM_W  = 49,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num_i,
   input  logic signed [31:0]      den_i,
   input  logic [SIDE_W-1:0]       side_i,
   output logic signed [31:0]      quot_o,
   output logic [SIDE_W-1:0]       side_o
);

   localparam int RW    = NUM_W + 1;
   localparam int CW    = (RW > 63) ? RW : 63;
   localparam int STEPS = 31;

   // magnitude stage
   logic [NUM_W-1:0]  a_ff;
   logic [31:0]       da_ff;
   logic              na_ff;
   logic [SIDE_W-1:0] sa_ff;
   // rounding bias stage
   logic [CW-1:0]     rb_ff;
   logic [31:0]       db_ff;
   logic              nb_ff;
   logic [SIDE_W-1:0] sb_ff;
   // bit steps; entry 0 holds the overflow check
   logic [CW-1:0]     rem_ff [STEPS+1];
   logic [CW-1:0]     rem_in [STEPS+1];
   logic [STEPS-1:0]  q_ff   [STEPS+1];
   logic [STEPS-1:0]  q_in   [STEPS+1];
   logic [31:0]       dd_ff  [STEPS+1];
   logic              ng_ff  [STEPS+1];
   logic              ov_ff  [STEPS+1];
   logic              ov_in;
   logic [SIDE_W-1:0] sd_ff  [STEPS+1];
   logic [NUM_W-1:0]  a_in;
   logic [31:0]       da_in;
   logic [CW-1:0]     trial;

   always_comb begin
      a_in  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      da_in = den_i[31] ? 32'(-den_i) : 32'(den_i);
      ov_in = rb_ff >= (CW'(db_ff) << STEPS);
      rem_in[0] = rb_ff;
      q_in[0]   = '0;
      trial     = '0;
      for (int k = 1; k <= STEPS; k++) begin
         trial = CW'(dd_ff[k-1]) << (STEPS - k);
         if (rem_ff[k-1] >= trial) begin
            rem_in[k] = rem_ff[k-1] - trial;
            q_in[k]   = q_ff[k-1] | (STEPS'(1) << (STEPS - k));
         end else begin
            rem_in[k] = rem_ff[k-1];
            q_in[k]   = q_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff  <= '0;
         sb_ff  <= '0;
         side_o <= '0;
         for (int k = 0; k <= STEPS; k++) begin
            sd_ff[k] <= '0;
         end
      end else if (en) begin
         a_ff  <= a_in;
         da_ff <= da_in;
         na_ff <= num_i[NUM_W-1] ^ den_i[31];
         sa_ff <= side_i;

         rb_ff <= CW'(a_ff) + CW'(da_ff >> 1);
         db_ff <= da_ff;
         nb_ff <= na_ff;
         sb_ff <= sa_ff;

         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         dd_ff[0]  <= db_ff;
         ng_ff[0]  <= nb_ff;
         ov_ff[0]  <= ov_in;
         sd_ff[0]  <= sb_ff;
         for (int k = 1; k <= STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            dd_ff[k]  <= dd_ff[k-1];
            ng_ff[k]  <= ng_ff[k-1];
            ov_ff[k]  <= ov_ff[k-1];
            sd_ff[k]  <= sd_ff[k-1];
         end

         side_o <= sd_ff[STEPS];
         if (ov_ff[STEPS]) begin
            quot_o <= ng_ff[STEPS] ? WORD_MIN : WORD_MAX;
         end else if (ng_ff[STEPS]) begin
            quot_o <= -$signed({1'b0, q_ff[STEPS]});
         end else begin
            quot_o <= $signed({1'b0, q_ff[STEPS]});
         end
      end
   end

endmodule

// ===== sv/cubic_spline_table_interpolator_top.sv =====
// Cubic spline table interpolator: knot tables, pipelined bracket search and
// the F, G, H evaluation datapath. Uses csti_pkg, csti_ram and csti_div.
//
// A load beat writes one knot (abscissa, value, second derivative) and gives
// no result; an evaluate beat gives one result with value, slope and a flag
// for a zero-width bracket. One beat of either kind is taken every cycle
// unless the result side stalls. An accepted evaluate beat passes through
// the binary search levels in order, each level reading its own copy of
// the abscissa table, then the multiply chain and two 35-stage dividers
// that resolve one quotient bit per cycle while the pipe advances, one for
// eps and one for the slope. Loads travel the same pipe and update each
// table copy as they pass it, so beats act in order. Knots must be loaded
// before they are searched; the user must write points_in_use only while
// the pipe is empty, which the block itself does not enforce.
module cubic_spline_table_interpolator_top import csti_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [POINTS_W-1:0]   csr_wr_data,   // points_in_use
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index[9:0], knot_abscissa[41:10], knot_value[73:42],
   // knot_curvature[105:74], query_x[137:106], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,     // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,     // value[31:0], slope[63:32]
   output logic [0:0]            rsp_tuser      // bad_spacing
);

   localparam int IW     = $clog2(TABLE_DEPTH);
   localparam int LEVELS = IW;
   localparam int EPS_NW = 33 + FRACTION_BITS;
   localparam int SLP_NW = 35 + FRACTION_BITS;
   localparam logic [WIDE_W-1:0] HALF_LSB = WIDE_W'(1) << (FRACTION_BITS - 1);
   localparam logic [63:0] H6_BIAS = 64'(3) << FRACTION_BITS;
   localparam logic [63:0] H2_BIAS = 64'(1) << FRACTION_BITS;
   localparam logic [63:0] T_LIMIT = 64'd6442450944;
   localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

   typedef struct packed {
      logic              valid;
      logic              load;
      logic              slot_ok;
      logic [IW-1:0]     slot;
      logic [IW-1:0]     lo;
      logic [IW-1:0]     hi;
      logic [IW-1:0]     mid;
      logic signed [31:0] x;
      logic signed [31:0] ab;
      logic signed [31:0] vl;
      logic signed [31:0] cv;
   } sr_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] h;
      logic signed [31:0] dy;
      logic signed [31:0] cs;
      logic signed [31:0] cd;
      logic signed [31:0] clo;
      logic signed [31:0] ylo;
      logic signed [31:0] h22;
      logic signed [31:0] h26;
      logic signed [31:0] g;
      logic signed [31:0] hc;
      logic signed [31:0] r1;
      logic signed [31:0] f;
      logic signed [32:0] dx;
      logic [63:0]        hh;
      logic [63:0]        plo;
      logic [32:0]        t;
      logic               t_ovf;
      logic signed [63:0] m1;
      logic signed [63:0] m2;
      logic signed [63:0] m3;
   } pre_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [31:0] ylo;
      logic signed [31:0] f;
      logic signed [31:0] g;
      logic signed [31:0] hc;
      logic signed [31:0] h;
   } dv_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [31:0] ylo;
      logic signed [31:0] f;
      logic signed [31:0] g;
      logic signed [31:0] hc;
      logic signed [31:0] h;
      logic signed [31:0] eps;
      logic signed [31:0] e2;
      logic signed [31:0] e3;
      logic signed [31:0] tf;
      logic signed [31:0] tg;
      logic signed [31:0] th;
      logic signed [31:0] sg;
      logic signed [31:0] sh;
      logic signed [31:0] value;
      logic signed [63:0] me2;
      logic signed [63:0] me3;
      logic signed [63:0] pf;
      logic signed [63:0] pg;
      logic signed [63:0] qg;
      logic signed [63:0] qh;
      logic signed [63:0] ph;
      logic signed [34:0] acc;
   } po_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [31:0] value;
   } sl_type;

   // product / 2^FRACTION_BITS, rounded half away from zero, saturated
   function automatic logic signed [31:0] fxr(input logic signed [63:0] p);
      logic signed [WIDE_W-1:0] w;
      logic [WIDE_W-1:0]        mag;
      logic [WIDE_W-1:0]        rmag;
      w    = WIDE_W'(p);
      mag  = w[WIDE_W-1] ? WIDE_W'(-w) : WIDE_W'(w);
      rmag = (mag + HALF_LSB) >> FRACTION_BITS;
      return w[WIDE_W-1] ? sat32(-$signed(rmag)) : sat32($signed(rmag));
   endfunction

   logic                  adv;
   logic [POINTS_W-1:0]   points_ff;
   logic [IW-1:0]         hi0;

   sr_type                sr_ff  [LEVELS];
   sr_type                sr_in  [LEVELS];
   logic [IW-1:0]         nlo    [LEVELS];
   logic [IW-1:0]         nhi    [LEVELS];
   logic signed [31:0]    lvl_rd [LEVELS];
   logic                  active;
   logic                  gt;

   sr_type                last;
   logic                  fin_wr;
   logic                  fin_valid_ff;
   logic signed [31:0]    fin_x_ff;
   logic signed [31:0]    xlo_rd, xhi_rd, ylo_rd, yhi_rd, clo_rd, chi_rd;

   pre_type               pre_ff [1:8];
   pre_type               pre_in [1:8];
   logic signed [63:0]    hsq;
   logic [63:0]           t64;
   logic [63:0]           h2w;
   logic [64:0]           p3sum;

   logic signed [EPS_NW-1:0] eps_num;
   dv_type                dv_side;
   dv_type                dv_out;
   logic signed [31:0]    eps_q;

   po_type                po_ff [1:7];
   po_type                po_in [1:7];

   logic signed [SLP_NW-1:0] slp_num;
   sl_type                sl_side;
   sl_type                sl_out;
   logic signed [31:0]    slope_q;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [0:0]            rsp_user_ff;

   // the whole pipe advances together; the output register is the only buffer
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_RESET;
      end else if (csr_wr_en) begin
         points_ff <= csr_wr_data;
      end
   end

   // clamp the knot count to [2, TABLE_DEPTH]
   always_comb begin
      if (points_ff < POINTS_W'(2)) begin
         hi0 = IW'(1);
      end else if (32'(points_ff) > TABLE_DEPTH) begin
         hi0 = IW'(TABLE_DEPTH - 1);
      end else begin
         hi0 = IW'(points_ff - POINTS_W'(1));
      end
   end

   // ---------------- bracket search ----------------
   always_comb begin
      sr_in[0].valid   = req_tvalid;
      sr_in[0].load    = (req_tuser == ACT_LOAD);
      sr_in[0].slot_ok = 32'(req_tdata[9:0]) < TABLE_DEPTH;
      sr_in[0].slot    = IW'(req_tdata[9:0]);
      sr_in[0].lo      = '0;
      sr_in[0].hi      = hi0;
      sr_in[0].mid     = hi0 >> 1;
      sr_in[0].ab      = $signed(req_tdata[41:10]);
      sr_in[0].vl      = $signed(req_tdata[73:42]);
      sr_in[0].cv      = $signed(req_tdata[105:74]);
      sr_in[0].x       = $signed(req_tdata[137:106]);
      active = 1'b0;
      gt     = 1'b0;
      for (int j = 0; j < LEVELS; j++) begin
         active = (sr_ff[j].hi - sr_ff[j].lo) > IW'(1);
         gt     = lvl_rd[j] > sr_ff[j].x;
         nlo[j] = (active && !gt) ? sr_ff[j].mid : sr_ff[j].lo;
         nhi[j] = (active && gt) ? sr_ff[j].mid : sr_ff[j].hi;
      end
      for (int j = 1; j < LEVELS; j++) begin
         sr_in[j]     = sr_ff[j-1];
         sr_in[j].lo  = nlo[j-1];
         sr_in[j].hi  = nhi[j-1];
         sr_in[j].mid = IW'(({1'b0, nlo[j-1]} + {1'b0, nhi[j-1]}) >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LEVELS; j++) begin
            sr_ff[j].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int j = 0; j < LEVELS; j++) begin
            sr_ff[j] <= sr_in[j];
         end
      end
   end

   // one abscissa copy per level; a load writes each copy as it passes
   for (genvar j = 0; j < LEVELS; j++) begin : g_lvl
      csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (adv && sr_in[j].valid && sr_in[j].load && sr_in[j].slot_ok),
         .wr_addr (sr_in[j].slot),
         .wr_data (sr_in[j].ab),
         .rd_en   (adv),
         .rd_addr (sr_in[j].mid),
         .rd_data (lvl_rd[j])
      );
   end

   assign last   = sr_ff[LEVELS-1];
   assign fin_wr = adv && last.valid && last.load && last.slot_ok;

   csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_xlo (
      .clock(clock), .wr_en(fin_wr), .wr_addr(last.slot), .wr_data(last.ab),
      .rd_en(adv), .rd_addr(nlo[LEVELS-1]), .rd_data(xlo_rd));
   csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_xhi (
      .clock(clock), .wr_en(fin_wr), .wr_addr(last.slot), .wr_data(last.ab),
      .rd_en(adv), .rd_addr(nhi[LEVELS-1]), .rd_data(xhi_rd));
   csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ylo (
      .clock(clock), .wr_en(fin_wr), .wr_addr(last.slot), .wr_data(last.vl),
      .rd_en(adv), .rd_addr(nlo[LEVELS-1]), .rd_data(ylo_rd));
   csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_yhi (
      .clock(clock), .wr_en(fin_wr), .wr_addr(last.slot), .wr_data(last.vl),
      .rd_en(adv), .rd_addr(nhi[LEVELS-1]), .rd_data(yhi_rd));
   csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_clo (
      .clock(clock), .wr_en(fin_wr), .wr_addr(last.slot), .wr_data(last.cv),
      .rd_en(adv), .rd_addr(nlo[LEVELS-1]), .rd_data(clo_rd));
   csti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_chi (
      .clock(clock), .wr_en(fin_wr), .wr_addr(last.slot), .wr_data(last.cv),
      .rd_en(adv), .rd_addr(nhi[LEVELS-1]), .rd_data(chi_rd));

   // loads end here; only evaluate beats go on
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= last.valid && !last.load;
         fin_x_ff     <= last.x;
      end
   end

   // ---------------- coefficients F, G, H ----------------
   always_comb begin
      for (int k = 2; k <= 8; k++) begin
         pre_in[k] = pre_ff[k-1];
      end
      pre_in[1]       = '0;
      pre_in[1].valid = fin_valid_ff;
      pre_in[1].h     = sat32(WIDE_W'(xhi_rd) - WIDE_W'(xlo_rd));
      pre_in[1].dx    = 33'(fin_x_ff) - 33'(xlo_rd);
      pre_in[1].dy    = sat32(WIDE_W'(yhi_rd) - WIDE_W'(ylo_rd));
      pre_in[1].cs    = sat32(WIDE_W'(clo_rd) + WIDE_W'(clo_rd) + WIDE_W'(chi_rd));
      pre_in[1].cd    = sat32(WIDE_W'(chi_rd) - WIDE_W'(clo_rd));
      pre_in[1].clo   = clo_rd;
      pre_in[1].ylo   = ylo_rd;

      hsq          = pre_ff[1].h * pre_ff[1].h;
      pre_in[2].hh = 64'(hsq);

      // h*h/6: add the rounding bias, shift right by F+1, then divide by three
      t64              = (pre_ff[2].hh + H6_BIAS) >> (FRACTION_BITS + 1);
      h2w              = (pre_ff[2].hh + H2_BIAS) >> (FRACTION_BITS + 1);
      pre_in[3].t      = t64[32:0];
      pre_in[3].t_ovf  = t64 >= T_LIMIT;
      pre_in[3].h22    = (h2w[63:31] != '0) ? WORD_MAX : $signed(h2w[31:0]);

      pre_in[4].plo = {32'b0, pre_ff[3].t[31:0]} * {32'b0, RECIP3};

      p3sum = {1'b0, pre_ff[4].plo} + (pre_ff[4].t[32] ? {1'b0, RECIP3, 32'b0} : 65'd0);
      pre_in[5].h26 = pre_ff[4].t_ovf ? WORD_MAX : $signed({1'b0, p3sum[63:33]});

      pre_in[6].m1 = pre_ff[5].h26 * pre_ff[5].cs;
      pre_in[6].m2 = pre_ff[5].h22 * pre_ff[5].clo;
      pre_in[6].m3 = pre_ff[5].h26 * pre_ff[5].cd;

      pre_in[7].r1 = fxr(pre_ff[6].m1);
      pre_in[7].g  = fxr(pre_ff[6].m2);
      pre_in[7].hc = fxr(pre_ff[6].m3);

      pre_in[8].f = sat32(WIDE_W'(pre_ff[7].dy) - WIDE_W'(pre_ff[7].r1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 8; k++) begin
            pre_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 1; k <= 8; k++) begin
            pre_ff[k] <= pre_in[k];
         end
      end
   end

   // ---------------- eps = (x - xlo) / h ----------------
   always_comb begin
      eps_num       = EPS_NW'(pre_ff[8].dx) <<< FRACTION_BITS;
      dv_side.valid = pre_ff[8].valid;
      dv_side.zero  = (pre_ff[8].h == '0);
      dv_side.ylo   = pre_ff[8].ylo;
      dv_side.f     = pre_ff[8].f;
      dv_side.g     = pre_ff[8].g;
      dv_side.hc    = pre_ff[8].hc;
      dv_side.h     = pre_ff[8].h;
   end

   csti_div #(.NUM_W(EPS_NW), .SIDE_W($bits(dv_type))) u_eps_div (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .num_i  (eps_num),
      .den_i  (pre_ff[8].h),
      .side_i (dv_side),
      .quot_o (eps_q),
      .side_o (dv_out)
   );

   // ---------------- value and slope numerator ----------------
   always_comb begin
      for (int k = 2; k <= 7; k++) begin
         po_in[k] = po_ff[k-1];
      end
      po_in[1]       = '0;
      po_in[1].valid = dv_out.valid;
      po_in[1].zero  = dv_out.zero;
      po_in[1].ylo   = dv_out.ylo;
      po_in[1].f     = dv_out.f;
      po_in[1].g     = dv_out.g;
      po_in[1].hc    = dv_out.hc;
      po_in[1].h     = dv_out.h;
      po_in[1].eps   = eps_q;
      po_in[1].me2   = eps_q * eps_q;

      po_in[2].e2 = fxr(po_ff[1].me2);

      po_in[3].me3 = po_ff[2].e2 * po_ff[2].eps;
      po_in[3].pf  = po_ff[2].eps * po_ff[2].f;
      po_in[3].pg  = po_ff[2].e2 * po_ff[2].g;
      po_in[3].qg  = po_ff[2].eps * po_ff[2].g;
      po_in[3].qh  = po_ff[2].e2 * po_ff[2].hc;

      po_in[4].e3 = fxr(po_ff[3].me3);
      po_in[4].tf = fxr(po_ff[3].pf);
      po_in[4].tg = fxr(po_ff[3].pg);
      po_in[4].sg = fxr(po_ff[3].qg);
      po_in[4].sh = fxr(po_ff[3].qh);

      po_in[5].ph = po_ff[4].e3 * po_ff[4].hc;

      po_in[6].th = fxr(po_ff[5].ph);

      po_in[7].value = sat32(WIDE_W'(po_ff[6].ylo) + WIDE_W'(po_ff[6].tf)
                             + WIDE_W'(po_ff[6].tg) + WIDE_W'(po_ff[6].th));
      po_in[7].acc   = 35'(po_ff[6].f) + 35'(po_ff[6].sg) + 35'(po_ff[6].sg)
                       + 35'(po_ff[6].sh) + 35'(po_ff[6].sh) + 35'(po_ff[6].sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 7; k++) begin
            po_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 1; k <= 7; k++) begin
            po_ff[k] <= po_in[k];
         end
      end
   end

   // ---------------- slope = numerator / h ----------------
   always_comb begin
      slp_num       = SLP_NW'(po_ff[7].acc) <<< FRACTION_BITS;
      sl_side.valid = po_ff[7].valid;
      sl_side.zero  = po_ff[7].zero;
      sl_side.value = po_ff[7].value;
   end

   csti_div #(.NUM_W(SLP_NW), .SIDE_W($bits(sl_type))) u_slope_div (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .num_i  (slp_num),
      .den_i  (po_ff[7].h),
      .side_i (sl_side),
      .quot_o (slope_q),
      .side_o (sl_out)
   );

   // hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sl_out.valid;
         rsp_user_ff  <= sl_out.zero;
         rsp_data_ff  <= sl_out.zero ? '0 : {slope_q, sl_out.value};
      end
   end

   // ---------------- checks ----------------
   a_zero_spacing_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[0] |-> rsp_data_ff == '0)
      else $error("bad_spacing result carries nonzero data");

   a_bracket_ordered: assert property (@(posedge clock) disable iff (reset)
      sr_ff[0].valid && !sr_ff[0].load |-> sr_ff[0].lo < sr_ff[0].hi)
      else $error("search bracket not ordered");

   a_search_converged: assert property (@(posedge clock) disable iff (reset)
      last.valid && !last.load |-> (nhi[LEVELS-1] - nlo[LEVELS-1]) == IW'(1))
      else $error("bracket search did not narrow to adjacent knots");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(po_ff[7]))
      else $error("pipeline moved during a stall");

endmodule

// ===== verif/cubic_spline_table_interpolator_top_test.sv =====
// Testbench for cubic_spline_table_interpolator_top: knot loads feed an
// in-bench fixed-point spline predictor, and every evaluation result is checked
// beat by beat against it. Depends on csti_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module cubic_spline_table_interpolator_top_test import csti_pkg::*;;

   localparam int DEPTH      = TABLE_DEPTH_DEF;
   localparam int FRAC       = FRACTION_BITS_DEF;
   localparam int DRAIN      = 120;
   localparam int MAX_CYCLES = 600000;

   typedef struct {
      action_type  act;
      logic [9:0]  slot;
      logic [31:0] kx;
      logic [31:0] ky;
      logic [31:0] kc;
      logic [31:0] qx;
   } knot_req_type;

   typedef struct {
      logic [31:0] value;
      logic [31:0] slope;
      logic        bad;
   } spline_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [POINTS_W-1:0]   csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   cubic_spline_table_interpolator_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   knot_req_type   pend_q[$];
   spline_out_type spline_q[$];
   knot_req_type   cur_req;
   int          knot_x[DEPTH];
   int          knot_y[DEPTH];
   int          knot_c[DEPTH];
   int          points = 1024;
   int          errors = 0;
   int          cycles = 0;
   int          results_seen = 0;
   bit          req_took = 0;
   bit          rsp_took = 0;
   bit          burst = 0;
   bit          held_once = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_left = 0;
   int          sent = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint rdiv(longint num, longint den);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clip32(rdiv(a * b, 64'sd1 << FRAC));
   endfunction

   function automatic spline_out_type spline_at(longint x);
      spline_out_type r;
      longint one, n, lo, hi, mid, xlo, xhi, ylo, yhi, clo, chi;
      longint h, h26, h22, eps, e2, e3, dy, cs, f, g, hc, acc;
      one = 64'sd1 << FRAC;
      n = points;
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (hi + lo) >> 1;
         if (longint'(knot_x[mid]) > x) hi = mid;
         else lo = mid;
      end
      xlo = knot_x[lo]; xhi = knot_x[hi];
      ylo = knot_y[lo]; yhi = knot_y[hi];
      clo = knot_c[lo]; chi = knot_c[hi];
      h = clip32(xhi - xlo);
      if (h == 0) begin
         r.value = '0;
         r.slope = '0;
         r.bad = 1'b1;
         return r;
      end
      h26 = clip32(rdiv(h * h, 6 * one));
      h22 = clip32(rdiv(h * h, 2 * one));
      eps = clip32(rdiv((x - xlo) * one, h));
      e2 = qmul(eps, eps);
      e3 = qmul(e2, eps);
      dy = clip32(yhi - ylo);
      cs = clip32(2 * clo + chi);
      f = clip32(dy - qmul(h26, cs));
      g = qmul(h22, clo);
      hc = qmul(h26, clip32(chi - clo));
      acc = ylo + qmul(eps, f) + qmul(e2, g) + qmul(e3, hc);
      r.value = 32'(clip32(acc));
      acc = f + 2 * qmul(eps, g) + 3 * qmul(e2, hc);
      r.slope = 32'(clip32(rdiv(acc * one, h)));
      r.bad = 1'b0;
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int any_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
         2: return int'($urandom_range(0, 1 << 27)) - (1 << 26);
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   task automatic push_load(int slot, int kx, int ky, int kc);
      knot_req_type it;
      it.act = ACT_LOAD;
      it.slot = 10'(slot);
      it.kx = kx; it.ky = ky; it.kc = kc;
      it.qx = $urandom;
      pend_q.push_back(it);
   endtask

   task automatic push_eval(int qx);
      knot_req_type it;
      it.act = ACT_EVAL;
      it.slot = 10'($urandom);
      it.kx = $urandom; it.ky = $urandom; it.kc = $urandom;
      it.qx = qx;
      pend_q.push_back(it);
   endtask

   // wait for an empty pipe, then write the count register
   task automatic set_points(int v);
      while (pend_q.size() != 0 || req_tvalid || spline_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= POINTS_W'(v);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // load n sorted knots into slots 0..n-1, returning the covered span
   task automatic load_sorted(int n, output longint x0, output longint xn);
      longint x;
      longint step;
      x = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      if ($urandom_range(0, 7) == 0) x = -64'sd2147483648;
      x0 = x;
      for (int i = 0; i < n; i++) begin
         push_load(i, int'(clip32(x)), any_word(), any_word());
         case ($urandom_range(0, 9))
            0: step = 0;
            1: step = $urandom_range(1, 1 << 30);
            default: step = $urandom_range(1, 1 << 20);
         endcase
         if (i != n - 1) x = clip32(x + step);
      end
      xn = x;
   endtask

   task automatic run_phase(int cfg, int evals);
      longint x0, xn, span;
      int      n;
      set_points(cfg);
      n = cfg < 2 ? 2 : (cfg > DEPTH ? DEPTH : cfg);
      if (n <= 32) load_sorted(n, x0, xn);
      else begin
         x0 = knot_x[0];
         xn = knot_x[n - 1];
      end
      span = xn - x0;
      if (span < 1) span = 1;
      for (int i = 0; i < evals; i++) begin
         case ($urandom_range(0, 11))
            0: push_load($urandom_range(0, DEPTH - 1), any_word(), any_word(), any_word());
            1: push_eval($urandom);
            2: push_eval($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
            3: push_eval(int'(clip32(x0 - longint'($urandom_range(0, 1 << 20)))));
            4: push_eval(int'(clip32(xn + longint'($urandom_range(0, 1 << 20)))));
            default: push_eval(int'(clip32(x0 + (longint'($urandom) % span))));
         endcase
      end
   endtask

   // ---------------- sequence ----------------
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: two-knot table, extremes, zero spacing, unsorted, last slot
      set_points(2);
      push_load(0, 0, 0, 0);
      push_load(1, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
      push_eval(0);
      push_eval(32'h0000_8000);
      push_eval(32'h0001_0000);
      push_eval(32'sh7FFF_FFFF);
      push_eval(32'sh8000_0000);
      push_load(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      push_load(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      push_eval(0);
      push_eval(32'sh7FFF_FFFF);
      push_load(1, 32'sh8000_0000, 0, 0);
      push_eval(5);
      push_load(0, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000);
      push_load(1, 32'h0001_0000, 32'hFFFE_0000, 32'h0002_0000);
      push_eval(32'h0002_0000);
      push_eval(32'h0004_0000);
      push_load(DEPTH - 1, 32'sh7FFF_FFFF, 1, -1);
      push_eval(32'h0000_4000);

      // fill every slot in ascending order so later searches see no holes
      set_points(DEPTH);
      for (int i = 0; i < DEPTH; i++)
         push_load(i, -32'sh4000_0000 + i * 32'h0010_0000, any_word(), any_word());

      run_phase(1024, 80);
      run_phase(2047, 40);
      run_phase(1500, 30);
      run_phase(0, 40);
      run_phase(1, 40);
      run_phase(2, 50);
      run_phase(3, 50);
      for (int p = 0; p < 8; p++)
         run_phase($urandom_range(0, 1) ? $urandom_range(4, 32) : $urandom_range(33, 1024), 55);
      run_phase(1024, 40);

      while (pend_q.size() != 0 || req_tvalid || spline_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && spline_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------- sampling at the rising edge ----------------
   always @(posedge clock) begin
      spline_out_type want;
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && csr_wr_en) points = int'(csr_wr_data);
      req_took = !reset && req_tvalid && req_tready;
      rsp_took = !reset && rsp_tvalid && rsp_tready;
      if (req_took) begin
         if (cur_req.act == ACT_LOAD) begin
            knot_x[cur_req.slot] = cur_req.kx;
            knot_y[cur_req.slot] = cur_req.ky;
            knot_c[cur_req.slot] = cur_req.kc;
         end else begin
            spline_q.push_back(spline_at(longint'($signed(cur_req.qx))));
         end
      end
      if (rsp_took) begin
         results_seen++;
         if (spline_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value=%h slope=%h bad=%b", $time,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0]);
         end else begin
            want = spline_q.pop_front();
            if (rsp_tdata[31:0] !== want.value || rsp_tdata[63:32] !== want.slope
                || rsp_tuser[0] !== want.bad) begin
               errors++;
               $display("%0t: mismatch expected value=%h slope=%h bad=%b, got value=%h slope=%h bad=%b",
                        $time, want.value, want.slope, want.bad,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0]);
            end
         end
      end
   end

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         // hold the beat until taken
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
         cur_req = pend_q.pop_front();
         req_tdata <= {6'b0, cur_req.qx, cur_req.kc, cur_req.ky, cur_req.kx, cur_req.slot};
         req_tuser <= cur_req.act;
         req_tvalid <= 1'b1;
         sent++;
         if (sent % 64 == 0) burst = $urandom_range(0, 1);
         send_gap = burst ? 0 : $urandom_range(0, 5);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------- result ready ----------------
   always @(negedge clock) begin
      if (!held_once && results_seen >= 40) begin
         held_once = 1;
         hold_left = 400;
      end
      if (rsp_took) recv_gap = burst ? 0 : $urandom_range(0, 5);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

endmodule
